// ===== src/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 message hasher
// Item structs for both channels, round constants and initial hash values.
// ----------------------------------------------------------------------------
package sha_pkg;

  // Input item: one message byte with presence and end marks
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_t;

  // Output item: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } dig_t;

  localparam int WinDepth = 16;
  localparam int Rounds   = 64;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== src/sha_ram.sv =====
// ----------------------------------------------------------------------------
// sha_ram: generic single-write, single-read RAM
// Read data is registered: data appears in the cycle after the address.
// ----------------------------------------------------------------------------
module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher: streaming SHA-256 over a byte-wide message
// Gathers 64-byte blocks in a 16-word RAM, compresses, pads, emits digest.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while input is not stalled; after every 64th
// byte input stalls for a compression of 64 rounds and then the hash update,
// each round stepping through phases set by the four schedule reads it makes
// through the single RAM read port. End of message adds padding writes and
// one or two compressions, then eight digest items, one per cycle when not
// stalled.
// Reset loads the initial hash values and clears the byte count; no clear pass.
module sha256_message_hasher (
  input  logic          clk,
  input  logic          rst,
  input  logic          msg_valid,
  output logic          msg_stall,
  input  sha_pkg::msg_t msg,
  output logic          dig_valid,
  input  logic          dig_stall,
  output sha_pkg::dig_t dig
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IN, S_HEAD, S_FILL, S_LEN_HI, S_LEN_LO, S_ROUND, S_ADD, S_OUT
  } state_t;

  typedef enum logic [1:0] {R_IN, R_HEAD, R_FILL, R_OUT} ret_t;

  state_t      state;
  ret_t        ret;
  logic [63:0] byte_count;
  logic [23:0] cur_word;
  logic [3:0]  fill_idx;
  logic        overflow;
  logic [5:0]  round_index;
  logic [2:0]  phase;
  logic [2:0]  out_idx;
  logic [31:0] hash_words [8];
  logic [31:0] v [8];
  logic [31:0] w16, w15, w7;

  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  logic [63:0] count_next;
  logic [31:0] head_word;
  logic [31:0] s0, s1, wt, t1, t2;
  logic        take;

  sha_ram #(.WIDTH(32), .DEPTH(WinDepth)) u_win (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign take       = msg_valid && !msg_stall;
  assign msg_stall  = (state != S_IN);
  assign count_next = byte_count + 64'd1;

  // First padding word: pending bytes, then 0x80, then zeros
  always_comb begin
    case (byte_count[1:0])
      2'd0:    head_word = 32'h8000_0000;
      2'd1:    head_word = {cur_word[7:0], 8'h80, 16'h0};
      2'd2:    head_word = {cur_word[15:0], 8'h80, 8'h0};
      default: head_word = {cur_word[23:0], 8'h80};
    endcase
  end

  // Schedule read sequence: w[t-16], w[t-15], w[t-7], w[t-2]
  always_comb begin
    case (phase)
      3'd0:    ram_raddr = round_index[3:0];
      3'd1:    ram_raddr = round_index[3:0] + 4'd1;
      3'd2:    ram_raddr = round_index[3:0] + 4'd9;
      default: ram_raddr = round_index[3:0] + 4'd14;
    endcase
  end

  // Round datapath; ram_rdata holds w[t-2] in the last phase
  always_comb begin
    s0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
    s1 = ror(ram_rdata, 17) ^ ror(ram_rdata, 19) ^ (ram_rdata >> 10);
    wt = (round_index < 6'd16) ? w16 : (w16 + s0 + w7 + s1);
    t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[round_index] + wt;
    t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Window write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_idx;
    ram_wdata = 32'h0;
    case (state)
      S_IN: begin
        ram_we    = take && msg.byte_present && (byte_count[1:0] == 2'd3);
        ram_waddr = byte_count[5:2];
        ram_wdata = {cur_word, msg.data_byte};
      end
      S_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = byte_count[5:2];
        ram_wdata = head_word;
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_LEN_HI: begin
        ram_we    = 1'b1;
        ram_waddr = 4'd14;
        ram_wdata = byte_count[60:29];
      end
      S_LEN_LO: begin
        ram_we    = 1'b1;
        ram_waddr = 4'd15;
        ram_wdata = {byte_count[28:0], 3'b000};
      end
      S_ROUND: begin
        ram_we    = (phase == 3'd4) && (round_index >= 6'd16);
        ram_waddr = round_index[3:0];
        ram_wdata = wt;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IN;
      ret         <= R_IN;
      byte_count  <= 64'd0;
      fill_idx    <= 4'd0;
      overflow    <= 1'b0;
      round_index <= 6'd0;
      phase       <= 3'd0;
      out_idx     <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        hash_words[i] <= InitH[i];
        v[i]          <= 32'h0;
      end
    end else begin
      case (state)
        S_IN: begin
          if (take) begin
            if (msg.byte_present) begin
              cur_word   <= {cur_word[15:0], msg.data_byte};
              byte_count <= count_next;
              if (count_next[5:0] == 6'd0) begin
                state       <= S_ROUND;
                ret         <= msg.end_of_message ? R_HEAD : R_IN;
                round_index <= 6'd0;
                phase       <= 3'd0;
                for (int i = 0; i < 8; i++) v[i] <= hash_words[i];
              end else if (msg.end_of_message) begin
                state <= S_HEAD;
              end
            end else if (msg.end_of_message) begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          overflow <= (byte_count[5:2] >= 4'd14);
          fill_idx <= byte_count[5:2] + 4'd1;
          if (byte_count[5:2] == 4'd15) begin
            state       <= S_ROUND;
            ret         <= R_FILL;
            round_index <= 6'd0;
            phase       <= 3'd0;
            for (int i = 0; i < 8; i++) v[i] <= hash_words[i];
          end else if (byte_count[5:2] == 4'd13) begin
            state <= S_LEN_HI;
          end else begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          fill_idx <= fill_idx + 4'd1;
          if (fill_idx == 4'd15) begin
            state       <= S_ROUND;
            ret         <= R_FILL;
            round_index <= 6'd0;
            phase       <= 3'd0;
            for (int i = 0; i < 8; i++) v[i] <= hash_words[i];
          end else if (fill_idx == 4'd13 && !overflow) begin
            state <= S_LEN_HI;
          end
        end
        S_LEN_HI: state <= S_LEN_LO;
        S_LEN_LO: begin
          state       <= S_ROUND;
          ret         <= R_OUT;
          round_index <= 6'd0;
          phase       <= 3'd0;
          for (int i = 0; i < 8; i++) v[i] <= hash_words[i];
        end
        S_ROUND: begin
          case (phase)
            3'd1: w16 <= ram_rdata;
            3'd2: w15 <= ram_rdata;
            3'd3: w7  <= ram_rdata;
            default: ;
          endcase
          if (phase == 3'd4) begin
            phase <= 3'd0;
            v[7] <= v[6];
            v[6] <= v[5];
            v[5] <= v[4];
            v[4] <= v[3] + t1;
            v[3] <= v[2];
            v[2] <= v[1];
            v[1] <= v[0];
            v[0] <= t1 + t2;
            round_index <= round_index + 6'd1;
            if (round_index == 6'(Rounds - 1)) begin
              state <= S_ADD;
            end
          end else begin
            phase <= phase + 3'd1;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + v[i];
          case (ret)
            R_IN:    state <= S_IN;
            R_HEAD:  state <= S_HEAD;
            R_FILL: begin
              // overflow block done: second block starts from word zero
              state    <= S_FILL;
              fill_idx <= 4'd0;
              overflow <= 1'b0;
            end
            default: begin
              state   <= S_OUT;
              out_idx <= 3'd0;
            end
          endcase
        end
        S_OUT: begin
          if (!dig_stall) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state      <= S_IN;
              byte_count <= 64'd0;
              for (int i = 0; i < 8; i++) hash_words[i] <= InitH[i];
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  // Digest output straight from the hash registers
  assign dig_valid       = (state == S_OUT);
  assign dig.digest_word = hash_words[out_idx];
  assign dig.last_word   = (out_idx == 3'd7);

  // Input and output never both open
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> msg_stall)
    else $error("digest shown while input open");

  // After the last digest item the block takes input again
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig.last_word && !dig_stall) |=> (!dig_valid && !msg_stall))
    else $error("block did not return to input after digest");

  // Round phase stays within its five steps
  a_phase: assert property (@(posedge clk) disable iff (rst)
    phase <= 3'd4)
    else $error("round phase out of range");

endmodule
